// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== sv/fucs_pkg.sv =====
// Package: shared constants, state encoding and control/status structs.
package fucs_pkg;

    localparam int SYM_W = 8;
    localparam int CNT_W = 2;

    localparam logic [CNT_W-1:0] CNT_SAT     = 2'd2;
    localparam logic [SYM_W-1:0] NONE_SYMBOL = 8'd35;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_UPDATE  = 6'b000010,
        S_POP_RD  = 6'b000100,
        S_POP_Q   = 6'b001000,
        S_POP_CHK = 6'b010000,
        S_OUT     = 6'b100000
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic q_rd;
        logic h_cnt_rd;
        logic pop;
        logic set_res;
        logic res_none;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic q_nonempty;
        logic head_dup;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/fucs_in_if.sv =====
// Input channel interface: one symbol per transaction.
interface fucs_in_if;
    logic                      valid;
    logic                      ready;
    logic [fucs_pkg::SYM_W-1:0] symbol;
    logic                      starts_string;

    modport source (output valid, output symbol, output starts_string, input ready);
    modport sink   (input valid, input symbol, input starts_string, output ready);
endinterface

// ===== sv/fucs_out_if.sv =====
// Output channel interface: one result per transaction.
interface fucs_out_if;
    logic                      valid;
    logic                      ready;
    logic [fucs_pkg::SYM_W-1:0] first_unique;
    logic                      none_found;

    modport source (output valid, output first_unique, output none_found, input ready);
    modport sink   (input valid, input first_unique, input none_found, output ready);
endinterface

// ===== sv/fucs_ctrl.sv =====
// Controller: sequences update, head pruning and result hand-off per symbol.
`include "assert_macros.svh"

module fucs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fucs_pkg::sts_t   sts,
    output fucs_pkg::cmd_t   cmd
);

    fucs_pkg::state_t state_reg;
    fucs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fucs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            fucs_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = fucs_pkg::S_UPDATE;
                end
            end
            fucs_pkg::S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = fucs_pkg::S_POP_RD;
            end
            fucs_pkg::S_POP_RD:
            begin
                if (sts.q_nonempty)
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = fucs_pkg::S_POP_Q;
                end
                else
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_none = 1'b1;
                    state_next   = fucs_pkg::S_OUT;
                end
            end
            fucs_pkg::S_POP_Q:
            begin
                cmd.h_cnt_rd = 1'b1;
                state_next   = fucs_pkg::S_POP_CHK;
            end
            fucs_pkg::S_POP_CHK:
            begin
                if (sts.head_dup)
                begin
                    cmd.pop    = 1'b1;
                    state_next = fucs_pkg::S_POP_RD;
                end
                else
                begin
                    cmd.set_res = 1'b1;
                    state_next  = fucs_pkg::S_OUT;
                end
            end
            fucs_pkg::S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = fucs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fucs_pkg::S_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_capture_to_update, clk, rst_n, cmd.capture, state_reg == fucs_pkg::S_UPDATE)
    `ASSERT_IMP(a_pop_needs_nonempty, clk, rst_n, cmd.q_rd, sts.q_nonempty)

endmodule

// ===== sv/fucs_dp.sv =====
// Datapath: count memory with valid bits, candidate queue, head/tail and result register.
`include "assert_macros.svh"

module fucs_dp #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fucs_pkg::cmd_t              cmd,
    output fucs_pkg::sts_t              sts,
    input  logic [fucs_pkg::SYM_W-1:0]  in_symbol,
    input  logic                        in_starts_string,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [fucs_pkg::SYM_W-1:0]  out_first_unique,
    output logic                        out_none_found
);

    localparam int IDX_W = $clog2(ALPHABET_SIZE);
    localparam int PTR_W = $clog2(ALPHABET_SIZE + 1);
    localparam logic [PTR_W-1:0]          PTR_LIM = PTR_W'(ALPHABET_SIZE);
    localparam logic [fucs_pkg::SYM_W:0]  SYM_LIM = (fucs_pkg::SYM_W + 1)'(ALPHABET_SIZE);

    logic [fucs_pkg::CNT_W-1:0] cnt_mem [ALPHABET_SIZE];
    logic [fucs_pkg::SYM_W-1:0] q_mem   [ALPHABET_SIZE];

    logic [ALPHABET_SIZE-1:0]   valid_reg;
    logic [fucs_pkg::SYM_W-1:0] sym_reg;
    logic [fucs_pkg::CNT_W-1:0] cnt_rd_reg;
    logic [fucs_pkg::SYM_W-1:0] q_data_reg;
    logic [PTR_W-1:0]           head_reg;
    logic [PTR_W-1:0]           tail_reg;
    logic [fucs_pkg::SYM_W-1:0] res_sym_reg;
    logic                       res_none_reg;
    logic                       out_valid_reg;
    logic [fucs_pkg::SYM_W-1:0] out_sym_reg;
    logic                       out_none_reg;

    logic [IDX_W-1:0]           sym_idx;
    logic [IDX_W-1:0]           head_sym_idx;
    logic [IDX_W-1:0]           cnt_rd_addr;
    logic                       sym_in_range;
    logic [fucs_pkg::CNT_W-1:0] sym_cnt;
    logic [fucs_pkg::CNT_W-1:0] sym_cnt_next;
    logic [fucs_pkg::CNT_W-1:0] head_cnt;
    logic                       do_enqueue;

    assign sym_idx      = sym_reg[IDX_W-1:0];
    assign head_sym_idx = q_data_reg[IDX_W-1:0];
    assign cnt_rd_addr  = cmd.capture ? in_symbol[IDX_W-1:0] : head_sym_idx;
    assign sym_in_range = {1'b0, sym_reg} < SYM_LIM;
    assign sym_cnt      = valid_reg[sym_idx] ? cnt_rd_reg : '0;
    assign sym_cnt_next = (sym_cnt == fucs_pkg::CNT_SAT) ? fucs_pkg::CNT_SAT
                                                         : sym_cnt + 2'd1;
    assign head_cnt     = valid_reg[head_sym_idx] ? cnt_rd_reg : '0;
    assign do_enqueue   = cmd.update && sym_in_range && (sym_cnt == '0) && (tail_reg < PTR_LIM);

    assign sts.q_nonempty = head_reg < tail_reg;
    assign sts.head_dup   = head_cnt > 2'd1;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_first_unique = out_sym_reg;
    assign out_none_found   = out_none_reg;

    // count memory: read on capture or head check, written on update
    always_ff @(posedge clk)
    begin
        if (cmd.capture || cmd.h_cnt_rd)
        begin
            cnt_rd_reg <= cnt_mem[cnt_rd_addr];
        end
        if (cmd.update && sym_in_range)
        begin
            cnt_mem[sym_idx] <= sym_cnt_next;
        end
    end

    // candidate queue memory
    always_ff @(posedge clk)
    begin
        if (cmd.q_rd)
        begin
            q_data_reg <= q_mem[head_reg[IDX_W-1:0]];
        end
        if (do_enqueue)
        begin
            q_mem[tail_reg[IDX_W-1:0]] <= sym_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sym_reg <= in_symbol;
        end
        if (cmd.set_res)
        begin
            res_none_reg <= cmd.res_none;
            res_sym_reg  <= cmd.res_none ? fucs_pkg::NONE_SYMBOL : q_data_reg;
        end
        if (cmd.emit)
        begin
            out_sym_reg  <= res_sym_reg;
            out_none_reg <= res_none_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture && in_starts_string)
            begin
                valid_reg <= '0;
                head_reg  <= '0;
                tail_reg  <= '0;
            end
            else
            begin
                if (cmd.update && sym_in_range)
                begin
                    valid_reg[sym_idx] <= 1'b1;
                end
                if (do_enqueue)
                begin
                    tail_reg <= tail_reg + 1'b1;
                end
                if (cmd.pop)
                begin
                    head_reg <= head_reg + 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_IMP(a_head_le_tail, clk, rst_n, 1'b1, head_reg <= tail_reg)
    `ASSERT_IMP(a_tail_in_bound, clk, rst_n, 1'b1, tail_reg <= PTR_LIM)
    `ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, !cmd.emit)
    `ASSERT_NEXT(a_pop_advances, clk, rst_n, cmd.pop, head_reg == $past(head_reg) + 1'b1)

endmodule

// ===== sv/first_unique_char_stream.sv =====
// Top level: first non-repeating symbol of a byte stream.
// Per symbol: capture and count update, then duplicates are popped from the queue head
// (queue read, count read, check) until the head survives or the queue is empty.
// Flow: one symbol at a time; input is accepted again once the result is registered at
// the output, which waits while the output is stalled.
// Reset: count valid bits, queue pointers and handshake state clear asynchronously on rst_n low.
module first_unique_char_stream #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    fucs_in_if.sink     din,
    fucs_out_if.source  dout
);

    fucs_pkg::cmd_t cmd;
    fucs_pkg::sts_t sts;

    fucs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fucs_dp #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_symbol        (din.symbol),
        .in_starts_string (din.starts_string),
        .out_ready        (dout.ready),
        .out_valid        (dout.valid),
        .out_first_unique (dout.first_unique),
        .out_none_found   (dout.none_found)
    );

endmodule

// ===== verif/tb.sv =====
// Testbench for first_unique_char_stream: random and directed symbol streams checked by a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SYM      = 256;
    localparam int IDLE_PCT   = 27;
    localparam int RAND_ITEMS = 700;
    localparam int QUIET_MAX  = 5000;
    localparam int TAIL_WAIT  = 40;

    typedef logic [fucs_pkg::SYM_W-1:0] sym_t;
    typedef logic [fucs_pkg::CNT_W-1:0] cnt_t;

    typedef struct packed {
        sym_t sym;
        logic start;
        logic drain;
    } sym_item_t;

    typedef struct packed {
        sym_t ch;
        logic none;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    fucs_in_if  din ();
    fucs_out_if dout ();

    first_unique_char_stream #(
        .ALPHABET_SIZE(N_SYM)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    always #10 clk = ~clk;

    sym_item_t symbols_to_send[$];
    answer_t   expected_answers[$];
    cnt_t      seen_tab[N_SYM];
    sym_t      order_tab[N_SYM];
    int        head_ptr;
    int        tail_ptr;
    int        n_accepted = 0;
    int        errors = 0;
    int        quiet_cycles;
    logic      in_fired;
    logic      calm;

    assign calm = (n_accepted >= 300) && (n_accepted < 430);

    // Predictor: saturating counts plus first-occurrence order of the current string.
    function automatic answer_t predict_first_unique(input sym_t sym, input logic start);
        answer_t r;
        if (start)
        begin
            foreach (seen_tab[i])
                seen_tab[i] = '0;
            head_ptr = 0;
            tail_ptr = 0;
        end
        if (int'(sym) < N_SYM)
        begin
            if (seen_tab[sym] == '0 && tail_ptr < N_SYM)
            begin
                order_tab[tail_ptr] = sym;
                tail_ptr++;
            end
            if (seen_tab[sym] < fucs_pkg::CNT_SAT)
                seen_tab[sym] = seen_tab[sym] + 1'b1;
        end
        while (head_ptr < tail_ptr && seen_tab[order_tab[head_ptr]] > 1)
            head_ptr++;
        if (head_ptr < tail_ptr)
            r = '{order_tab[head_ptr], 1'b0};
        else
            r = '{fucs_pkg::NONE_SYMBOL, 1'b1};
        return r;
    endfunction

    task automatic add_item(input sym_t s, input logic st, input logic dr = 1'b0);
        sym_item_t it;
        it = '{s, st, dr};
        symbols_to_send.insert(symbols_to_send.size(), it);
    endtask

    initial
    begin
        din.valid         = 1'b0;
        din.symbol        = '0;
        din.starts_string = 1'b0;
        dout.ready        = 1'b0;
        rst_n             = 1'b0;
        foreach (seen_tab[i])
            seen_tab[i] = '0;
        head_ptr = 0;
        tail_ptr = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
    end

    // Stimulus and end of run
    initial
    begin
        int   n_rand;
        int   len;
        int   mode;
        int   k;
        int   j;
        bit   perm_done;
        sym_t pool[8];
        sym_t perm[N_SYM];
        sym_t tmp;

        // directed: extremes, saturation, '#' as a real symbol, restarts
        add_item(8'h5A, 1'b0);
        add_item(8'h5A, 1'b0);
        add_item(8'h5A, 1'b0);
        add_item(8'h00, 1'b1);
        add_item(8'hFF, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h23, 1'b0);
        add_item(8'h23, 1'b0);
        add_item(8'h23, 1'b1);
        add_item(8'hA5, 1'b0);
        add_item(8'h5A, 1'b0);
        add_item(8'h23, 1'b0);
        add_item(8'hA5, 1'b0);
        add_item(8'h5A, 1'b0);
        add_item(8'h80, 1'b1);
        add_item(8'h7F, 1'b0);
        add_item(8'h01, 1'b0);
        add_item(8'hFE, 1'b0);
        add_item(8'h7F, 1'b0);
        add_item(8'h80, 1'b0);
        add_item(8'h01, 1'b0);
        add_item(8'hFE, 1'b0);
        add_item(8'hFE, 1'b1);

        n_rand    = 0;
        perm_done = 1'b0;
        while (n_rand < RAND_ITEMS)
        begin
            mode = $urandom_range(9);
            if (!perm_done && n_rand > 200)
            begin
                // whole alphabet in one string: fills the queue, then a long head skip
                perm_done = 1'b1;
                for (int i = 0; i < N_SYM; i++)
                    perm[i] = sym_t'(i);
                for (int i = N_SYM - 1; i > 0; i--)
                begin
                    j       = $urandom_range(i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                add_item(perm[0], 1'b1, 1'b1);
                for (int i = 1; i < N_SYM; i++)
                    add_item(perm[i], 1'b0);
                for (int i = 1; i <= 50; i++)
                    add_item(perm[i], 1'b0);
                add_item(perm[0], 1'b0);
                for (int i = 0; i < 30; i++)
                    add_item(sym_t'($urandom_range(255)), 1'b0);
                n_rand += N_SYM + 81;
            end
            else if (mode <= 6)
            begin
                k = $urandom_range(8, 2);
                for (int i = 0; i < k; i++)
                    pool[i] = sym_t'($urandom_range(255));
                len = $urandom_range(24, 1);
                for (int i = 0; i < len; i++)
                    add_item(pool[$urandom_range(k - 1)], i == 0, n_rand == 0 && i == 0);
                n_rand += len;
            end
            else
            begin
                len = $urandom_range(16, 1);
                for (int i = 0; i < len; i++)
                    add_item(sym_t'($urandom_range(255)), $urandom_range(15) == 0);
                n_rand += len;
            end
        end

        wait (rst_n === 1'b1);
        while (symbols_to_send.size() != 0 || din.valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Driver: both handshake sides change at the falling edge
    always @(negedge clk)
    begin
        sym_item_t nxt;
        if (!rst_n)
        begin
            din.valid  <= 1'b0;
            dout.ready <= 1'b0;
        end
        else
        begin
            dout.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (!din.valid || in_fired)
            begin
                if (symbols_to_send.size() == 0
                    || (!calm && $urandom_range(99) < IDLE_PCT)
                    || (symbols_to_send[0].drain && expected_answers.size() != 0))
                begin
                    din.valid <= 1'b0;
                end
                else
                begin
                    nxt = symbols_to_send.pop_front();
                    din.valid         <= 1'b1;
                    din.symbol        <= nxt.sym;
                    din.starts_string <= nxt.start;
                end
            end
        end
    end

    // Monitor, scoreboard and watchdog
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        answer_t pred;
        if (!rst_n)
        begin
            in_fired     <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_fired <= din.valid && din.ready;
            if (din.valid && din.ready)
            begin
                pred = predict_first_unique(din.symbol, din.starts_string);
                expected_answers.insert(expected_answers.size(), pred);
                n_accepted++;
            end
            if (dout.valid && dout.ready)
            begin
                got = '{dout.first_unique, dout.none_found};
                if (expected_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none, got %02h/%0b",
                             $time, got.ch, got.none);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.ch !== want.ch)
                    begin
                        errors++;
                        $display("%0t: first_unique expected %02h, got %02h",
                                 $time, want.ch, got.ch);
                    end
                    if (got.none !== want.none)
                    begin
                        errors++;
                        $display("%0t: none_found expected %0b, got %0b",
                                 $time, want.none, got.none);
                    end
                end
            end
            if ((din.valid && din.ready) || (dout.valid && dout.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_MAX)
            begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_MAX);
                $display("tb failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
